[src/nsm_pkg.sv]
package nsm_pkg;

    // Default sizes handed to the top level parameters.
    localparam int TERM_MAX_DEF = 32;
    localparam int TEXT_MAX_DEF = 4096;

    // Fixed field widths of the request and result items.
    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int INDEX_W  = 5;
    localparam int LEN_W    = 6;
    localparam int START_W  = 12;

    // The free-running byte count saturates at this value.
    localparam logic [LEN_W-1:0] RUN_MAX = '1;

    // Configuration port geometry and register map.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_LEN = 2'd0;

    // Request kinds carried in the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_TERM = 2'd0,
        ACT_TEXT      = 2'd1,
        ACT_START     = 2'd2
    } action_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SYMBOL_W-1:0] symbol;
        logic [INDEX_W-1:0]  term_index;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0] match_start;
    } out_item_t;

endpackage

[src/nsm_ifs.sv]
interface nsm_in_if
    import nsm_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface nsm_out_if
    import nsm_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

[src/nonoverlapping_substring_matcher_unit.sv]
// Non-overlapping substring matcher.
//
// Requests arrive on text_in (valid/ready). A request either loads one term
// byte at term_index, feeds one text byte, or starts a new text. The term
// length is set through the APB register at address 0 (zero disables
// matching). For each text byte that completes an occurrence of the term, one
// result leaves on match_out carrying the text position of the occurrence's
// first byte; a new occurrence never starts inside a reported one.
// A result passes the input register, then the result register, after its
// request is accepted. One request per cycle is taken while match_out does
// not stall; the window compare against all term bytes is combinational.
// When match_out stalls, the result register holds and the input register
// fills; text_in drops ready only while both registers are full and the
// result is not taken.
// Reset clears the text window, byte count, position, term length and both
// valid flags. The term bytes are not cleared and must be loaded before use.
// Configuration writes are meant for idle periods only.
module nonoverlapping_substring_matcher_unit
    import nsm_pkg::*;
#(
    parameter int TERM_MAX = TERM_MAX_DEF,
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    nsm_in_if.sink                text_in,
    nsm_out_if.source             match_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int WIN_IDX_W = (TERM_MAX > 1) ? $clog2(TERM_MAX) : 1;
    localparam int POS_W     = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
    localparam int MOD_DEPTH = 2 ** LEN_W;

    // Configuration register.
    logic [LEN_W-1:0] pat_len_reg;

    // Input register.
    logic     in_valid_reg;
    in_item_t in_reg;

    // Block state.
    logic [SYMBOL_W-1:0] term_store [TERM_MAX];
    logic [SYMBOL_W-1:0] window_reg [TERM_MAX];
    logic [SYMBOL_W-1:0] window_next [TERM_MAX];
    logic [LEN_W-1:0]    run_reg;
    logic [LEN_W-1:0]    run_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;

    // Result register.
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;

    // Datapath signals.
    logic                 advance;
    logic                 in_ready;
    logic                 is_text;
    logic                 len_ok;
    logic                 window_eq;
    logic                 hit;
    logic [LEN_W-1:0]     len_m1;
    logic [LEN_W-1:0]     run_inc;
    logic [POS_W-1:0]     len_mod [MOD_DEPTH];
    logic [POS_W-1:0]     back_off;
    logic [POS_W:0]       start_wide;
    logic [POS_W-1:0]     start_pos;
    logic [TERM_MAX-1:0]  byte_eq;

    // APB register access; only the pattern length is writable.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_PAT_LEN)
                    ? CFG_DATA_W'(pat_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_PAT_LEN))
        begin
            pat_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Handshake: the pipeline moves when the result register has room.
    assign advance         = in_valid_reg && (!out_valid_reg || match_out.ready);
    assign in_ready        = !in_valid_reg || advance;
    assign text_in.ready   = in_ready;
    assign match_out.valid = out_valid_reg;
    assign match_out.item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && text_in.valid)
        begin
            in_reg <= text_in.item;
        end
    end

    // Window after shifting in the current text byte.
    assign is_text = (in_reg.action == ACT_TEXT);

    always_comb
    begin
        window_next[0] = in_reg.symbol;
        for (int k = 1; k < TERM_MAX; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
    end

    // Term byte j lines up with the text byte received len-1-j text bytes ago.
    assign len_m1 = pat_len_reg - LEN_W'(1);

    always_comb
    begin
        logic [LEN_W-1:0] offs;
        for (int j = 0; j < TERM_MAX; j++)
        begin
            offs = len_m1 - LEN_W'(j);
            if (j < int'(pat_len_reg))
            begin
                byte_eq[j] = (window_next[offs[WIN_IDX_W-1:0]] == term_store[j]);
            end
            else
            begin
                byte_eq[j] = 1'b1;
            end
        end
    end

    assign window_eq = &byte_eq;
    assign len_ok    = (pat_len_reg != '0) && (int'(pat_len_reg) <= TERM_MAX);
    assign run_inc   = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + LEN_W'(1);
    assign hit       = is_text && len_ok && (run_inc >= pat_len_reg) && window_eq;

    // Start position: current position minus (length - 1), modulo TEXT_MAX.
    for (genvar g = 0; g < MOD_DEPTH; g++)
    begin : g_len_mod
        assign len_mod[g] = POS_W'(g % TEXT_MAX);
    end

    assign back_off   = len_mod[len_m1];
    assign start_wide = (pos_reg >= back_off)
                        ? {1'b0, pos_reg} - {1'b0, back_off}
                        : {1'b0, pos_reg} + (POS_W+1)'(TEXT_MAX) - {1'b0, back_off};
    assign start_pos  = start_wide[POS_W-1:0];

    // Next values of the text state.
    always_comb
    begin
        run_next = run_reg;
        pos_next = pos_reg;
        unique case (in_reg.action)
            ACT_TEXT:
            begin
                run_next = hit ? '0 : run_inc;
                pos_next = (pos_reg == POS_W'(TEXT_MAX - 1)) ? '0 : pos_reg + POS_W'(1);
            end
            ACT_START:
            begin
                run_next = '0;
                pos_next = '0;
            end
            default:
            begin
                run_next = run_reg;
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            pos_reg <= '0;
            for (int k = 0; k < TERM_MAX; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            run_reg <= run_next;
            pos_reg <= pos_next;
            if (in_reg.action == ACT_TEXT)
            begin
                window_reg <= window_next;
            end
            else if (in_reg.action == ACT_START)
            begin
                for (int k = 0; k < TERM_MAX; k++)
                begin
                    window_reg[k] <= '0;
                end
            end
        end
    end

    // Term byte loads; indexes past the store are dropped.
    always_ff @(posedge clk)
    begin
        if (advance && (in_reg.action == ACT_LOAD_TERM)
            && (int'(in_reg.term_index) < TERM_MAX))
        begin
            term_store[WIN_IDX_W'(in_reg.term_index)] <= in_reg.symbol;
        end
    end

    // Result register.
    assign out_valid_next = advance ? hit : (match_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            out_reg.match_start <= START_W'(start_pos);
        end
    end

    // A reported match restarts the byte count, so no overlap can follow.
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hit) |=> (run_reg == '0))
        else $error("byte count not cleared after a match");

    // Input stalls only when both registers are full and the result is not taken.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !match_out.ready))
        else $error("input stalled with room in the pipeline");

    // Position stays inside the text range.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(pos_reg) < TEXT_MAX)
        else $error("text position out of range");

    // A new result comes only from a text byte.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && (in_reg.action == ACT_TEXT)))
        else $error("result produced by a non-text request");

endmodule
